@@ src/hla_pkg.sv @@
// Shared types, codes and the sine table of the Hough line accumulator.
package hla_pkg;

   localparam int ANGLE_BINS = 181;
   localparam int ANGLE_MAX = 180;
   localparam int SIN_W = 15;
   localparam int MEAN_RECIP = 5243;
   localparam int MEAN_SHIFT = 17;

   typedef enum logic [1:0] {
      KIND_VOTE  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_RHO_COUNT = 1'b1;

   localparam logic [7:0] VOTE_PIXEL = 8'd255;
   localparam logic [7:0] VOTE_INCREMENT = 8'd2;
   localparam logic [7:0] THRESHOLD_RESET = 8'd20;
   localparam logic [10:0] RHO_COUNT_RESET = 11'd724;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_item;
      logic       vote_en;
      logic       nbr_en;
      logic       clr_en;
      logic       sweep_en;
      logic       mean_en;
      logic       rsp_load;
      logic [7:0] angle;
      logic [2:0] dr;
      logic [2:0] da;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_last;
   } dp_status_type;

   localparam logic [SIN_W-1:0] SIN_Q14_TABLE [91] = '{
      15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
      15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
      15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
      15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
      15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
      15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
      15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
      15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
      15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
      15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
      15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
      15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
      15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
      15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
   };

   // Sine of k degrees in unsigned Q1.14 for k from 0 to 90.
   function automatic logic [SIN_W-1:0] sin_q14(input logic [6:0] k);
      logic [SIN_W-1:0] val;
      val = '0;
      if (k <= 7'd90) begin
         val = SIN_Q14_TABLE[k];
      end
      return val;
   endfunction

endpackage

@@ src/hla_if.sv @@
// Request and response channel interfaces of the Hough line accumulator.
interface hla_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [8:0] pixel_row;
   logic [8:0] pixel_col;
   logic [7:0] pixel_value;
   logic [9:0] rho_index;
   logic [7:0] angle_index;

   modport source (output valid, kind, pixel_row, pixel_col, pixel_value, rho_index,
                   angle_index, input ready);
   modport sink (input valid, kind, pixel_row, pixel_col, pixel_value, rho_index,
                 angle_index, output ready);
endinterface

interface hla_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] cell_count;
   logic [7:0] local_mean;
   logic       is_peak;

   modport source (output valid, cell_count, local_mean, is_peak, input ready);
   modport sink (input valid, cell_count, local_mean, is_peak, output ready);
endinterface

@@ src/hla_ctrl.sv @@
// Sequencing state machine of the Hough line accumulator.
module hla_ctrl
   import hla_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_kind,
   input  logic [7:0]    req_pixel_value,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [5:0] {
      ST_SWEEP = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_VOTE  = 6'b000100,
      ST_READ  = 6'b001000,
      ST_CLEAR = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   localparam logic [7:0] VOTE_LAST = 8'd180;
   localparam logic [7:0] VOTE_END = 8'd186;
   localparam logic [7:0] NBR_LAST = 8'd24;
   localparam logic [7:0] MEAN_STEP = 8'd29;
   localparam logic [7:0] RSP_STEP = 8'd30;
   localparam logic [2:0] OFS_LAST = 3'd4;

   state_type  state_ff, state_in;
   logic [7:0] cnt_ff, cnt_in;
   logic [2:0] dr_ff, dr_in;
   logic [2:0] da_ff, da_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      dr_in = dr_ff;
      da_in = da_ff;
      cmd = '0;
      cmd.angle = cnt_ff;
      cmd.dr = dr_ff;
      cmd.da = da_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_en = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cnt_in = '0;
            dr_in = '0;
            da_in = '0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               case (req_kind)
                  KIND_VOTE: begin
                     if (req_pixel_value == VOTE_PIXEL) begin
                        state_in = ST_VOTE;
                     end
                  end
                  KIND_READ: state_in = ST_READ;
                  KIND_CLEAR: state_in = ST_CLEAR;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_VOTE: begin
            cmd.vote_en = (cnt_ff <= VOTE_LAST);
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff == VOTE_END) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff <= NBR_LAST) begin
               cmd.nbr_en = 1'b1;
               if (da_ff == OFS_LAST) begin
                  da_in = '0;
                  dr_in = dr_ff + 3'd1;
               end else begin
                  da_in = da_ff + 3'd1;
               end
            end
            cmd.mean_en = (cnt_ff == MEAN_STEP);
            if (cnt_ff == RSP_STEP) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            state_in = ST_IDLE;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         cnt_ff <= '0;
         dr_ff <= '0;
         da_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         dr_ff <= dr_in;
         da_ff <= da_in;
      end
   end

endmodule

@@ src/hla_datapath.sv @@
// Vote store, vote and neighbourhood pipelines and result registers.
module hla_datapath
   import hla_pkg::*;
#(
   parameter int RHO_BINS = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [8:0]    req_pixel_row,
   input  logic [8:0]    req_pixel_col,
   input  logic [9:0]    req_rho_index,
   input  logic [7:0]    req_angle_index,
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic [10:0]   csr_wr_data,
   output logic [7:0]    rsp_cell_count,
   output logic [7:0]    rsp_local_mean,
   output logic          rsp_is_peak
);

   localparam int DEPTH = RHO_BINS * ANGLE_BINS;
   localparam int AW = $clog2(DEPTH);
   localparam int RW = $clog2(RHO_BINS);
   localparam int CW = ($clog2(RHO_BINS + 1) + 1 > 12) ? $clog2(RHO_BINS + 1) + 1 : 12;

   logic [7:0] mem [DEPTH];

   // Configuration registers.
   logic [7:0]  threshold_ff, threshold_in;
   logic [10:0] rho_count_ff, rho_count_in;
   logic [CW-1:0] lim;

   always_comb begin
      threshold_in = threshold_ff;
      rho_count_in = rho_count_ff;
      if (csr_wr_en && csr_index == CSR_THRESHOLD) begin
         threshold_in = csr_wr_data[7:0];
      end
      if (csr_wr_en && csr_index == CSR_RHO_COUNT) begin
         rho_count_in = csr_wr_data;
      end
      lim = (CW'(rho_count_ff) < CW'(RHO_BINS)) ? CW'(rho_count_ff) : CW'(RHO_BINS);
   end

   // Clearing sweep counter.
   logic [AW-1:0] sweep_ff, sweep_in;

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_en) begin
         sweep_in = sweep_ff + AW'(1);
      end
      status.sweep_last = (sweep_ff == AW'(DEPTH - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         rho_count_ff <= RHO_COUNT_RESET;
         sweep_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
         rho_count_ff <= rho_count_in;
         sweep_ff <= sweep_in;
      end
   end

   // Item registers.
   logic [8:0] row_ff, col_ff;
   logic [9:0] rho_ff;
   logic [7:0] ang_ff;
   logic       in_store;
   logic [AW-1:0] item_addr;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         row_ff <= req_pixel_row;
         col_ff <= req_pixel_col;
         rho_ff <= req_rho_index;
         ang_ff <= req_angle_index;
      end
   end

   always_comb begin
      in_store = (CW'(rho_ff) < CW'(RHO_BINS)) && (ang_ff <= 8'(ANGLE_MAX));
      item_addr = AW'(rho_ff) * AW'(ANGLE_BINS) + AW'(ang_ff);
   end

   // Vote stage 0: sine and cosine lookup.
   logic                 v0_valid_ff, v0_valid_in;
   logic [7:0]           v0_ang_ff, v0_ang_in;
   logic [SIN_W-1:0]     v0_s_ff, v0_s_in, v0_c_ff, v0_c_in;
   logic                 v0_neg_ff, v0_neg_in;

   always_comb begin
      v0_valid_in = cmd.vote_en;
      v0_ang_in = cmd.angle;
      if (cmd.angle <= 8'd90) begin
         v0_s_in = sin_q14(cmd.angle[6:0]);
         v0_c_in = sin_q14(7'(8'd90 - cmd.angle));
         v0_neg_in = 1'b0;
      end else begin
         v0_s_in = sin_q14(7'(8'(ANGLE_MAX) - cmd.angle));
         v0_c_in = sin_q14(7'(cmd.angle - 8'd90));
         v0_neg_in = 1'b1;
      end
   end

   // Vote stage 1: products.
   logic        v1_valid_ff, v1_valid_in;
   logic [7:0]  v1_ang_ff, v1_ang_in;
   logic [23:0] v1_ps_ff, v1_ps_in, v1_pc_ff, v1_pc_in;
   logic        v1_neg_ff, v1_neg_in;

   always_comb begin
      v1_valid_in = v0_valid_ff;
      v1_ang_in = v0_ang_ff;
      v1_ps_in = 24'(row_ff) * 24'(v0_s_ff);
      v1_pc_in = 24'(col_ff) * 24'(v0_c_ff);
      v1_neg_in = v0_neg_ff;
   end

   // Cell stage: rho from the vote pipeline or a neighbour of the read item.
   logic [24:0] mag;
   logic [10:0] vote_rho;
   logic signed [CW-1:0] nbr_r;
   logic signed [9:0] nbr_a;
   logic        nbr_ok;
   logic          c2_vote_ff, c2_vote_in;
   logic          c2_nbr_ff, c2_nbr_in;
   logic          c2_ok_ff, c2_ok_in;
   logic          c2_center_ff, c2_center_in;
   logic [RW-1:0] c2_rho_ff, c2_rho_in;
   logic [7:0]    c2_ang_ff, c2_ang_in;

   always_comb begin
      if (v1_neg_ff) begin
         if (v1_ps_ff >= v1_pc_ff) begin
            mag = 25'(v1_ps_ff - v1_pc_ff);
         end else begin
            mag = 25'(v1_pc_ff - v1_ps_ff);
         end
      end else begin
         mag = 25'(v1_ps_ff) + 25'(v1_pc_ff);
      end
      vote_rho = mag[24:14];
      nbr_r = CW'(rho_ff) + CW'(cmd.dr) - CW'(2);
      nbr_a = 10'(ang_ff) + 10'(cmd.da) - 10'd2;
      nbr_ok = !nbr_r[CW-1] && (nbr_r < CW'(RHO_BINS)) && !nbr_a[9] &&
               (nbr_a <= 10'(ANGLE_MAX));
      c2_vote_in = v1_valid_ff && (CW'(vote_rho) < lim);
      c2_nbr_in = cmd.nbr_en;
      c2_ok_in = cmd.nbr_en ? nbr_ok : 1'b1;
      c2_center_in = (cmd.dr == 3'd2) && (cmd.da == 3'd2);
      if (cmd.nbr_en) begin
         c2_rho_in = nbr_ok ? RW'(nbr_r) : '0;
         c2_ang_in = nbr_ok ? 8'(nbr_a) : '0;
      end else begin
         c2_rho_in = RW'(vote_rho);
         c2_ang_in = v1_ang_ff;
      end
   end

   // Address stage.
   logic          a3_vote_ff, a3_nbr_ff, a3_ok_ff, a3_center_ff;
   logic [AW-1:0] a3_addr_ff, a3_addr_in;

   always_comb begin
      a3_addr_in = AW'(c2_rho_ff) * AW'(ANGLE_BINS) + AW'(c2_ang_ff);
   end

   // Read stage and accumulation.
   logic          m4_vote_ff, m4_nbr_ff, m4_ok_ff, m4_center_ff;
   logic [AW-1:0] m4_addr_ff;
   logic [7:0]    rdata_ff;
   logic [7:0]    nbr_val;
   logic [12:0]   sum_ff, sum_in;
   logic [7:0]    cell_ff, cell_in;
   logic [7:0]    mean_ff, mean_in;
   logic [25:0]   mean_prod;

   always_comb begin
      nbr_val = m4_ok_ff ? rdata_ff : 8'd0;
      sum_in = sum_ff;
      cell_in = cell_ff;
      if (cmd.load_item) begin
         sum_in = '0;
      end else if (m4_nbr_ff) begin
         sum_in = sum_ff + 13'(nbr_val);
         if (m4_center_ff) begin
            cell_in = nbr_val;
         end
      end
      mean_prod = 26'(sum_ff) * 26'(MEAN_RECIP);
      mean_in = cmd.mean_en ? mean_prod[MEAN_SHIFT +: 8] : mean_ff;
   end

   always_ff @(posedge clock) begin
      v0_valid_ff <= v0_valid_in;
      v0_ang_ff <= v0_ang_in;
      v0_s_ff <= v0_s_in;
      v0_c_ff <= v0_c_in;
      v0_neg_ff <= v0_neg_in;
      v1_valid_ff <= v1_valid_in;
      v1_ang_ff <= v1_ang_in;
      v1_ps_ff <= v1_ps_in;
      v1_pc_ff <= v1_pc_in;
      v1_neg_ff <= v1_neg_in;
      c2_vote_ff <= c2_vote_in;
      c2_nbr_ff <= c2_nbr_in;
      c2_ok_ff <= c2_ok_in;
      c2_center_ff <= c2_center_in;
      c2_rho_ff <= c2_rho_in;
      c2_ang_ff <= c2_ang_in;
      a3_vote_ff <= c2_vote_ff;
      a3_nbr_ff <= c2_nbr_ff;
      a3_ok_ff <= c2_ok_ff;
      a3_center_ff <= c2_center_ff;
      a3_addr_ff <= a3_addr_in;
      m4_vote_ff <= a3_vote_ff;
      m4_nbr_ff <= a3_nbr_ff;
      m4_ok_ff <= a3_ok_ff;
      m4_center_ff <= a3_center_ff;
      m4_addr_ff <= a3_addr_ff;
      sum_ff <= sum_in;
      cell_ff <= cell_in;
      mean_ff <= mean_in;
   end

   // Single store port pair: one read and one write address per cycle.
   always_ff @(posedge clock) begin
      rdata_ff <= mem[a3_addr_ff];
      if (cmd.sweep_en) begin
         mem[sweep_ff] <= 8'd0;
      end else if (cmd.clr_en && in_store) begin
         mem[item_addr] <= 8'd0;
      end else if (m4_vote_ff) begin
         mem[m4_addr_ff] <= rdata_ff + VOTE_INCREMENT;
      end
   end

   // Result registers.
   logic interior;
   logic [7:0] cell_out_in, mean_out_in;
   logic peak_out_in;
   logic [7:0] cell_out_ff, mean_out_ff;
   logic peak_out_ff;

   always_comb begin
      interior = (rho_ff >= 10'd2) && ((CW'(rho_ff) + CW'(2)) < lim) &&
                 (ang_ff >= 8'd2) && (ang_ff <= 8'(ANGLE_MAX - 2));
      cell_out_in = cell_out_ff;
      mean_out_in = mean_out_ff;
      peak_out_in = peak_out_ff;
      if (cmd.rsp_load) begin
         cell_out_in = in_store ? cell_ff : 8'd0;
         mean_out_in = in_store ? mean_ff : 8'd0;
         peak_out_in = in_store && interior && (cell_ff > mean_ff) &&
                       ((cell_ff - mean_ff) > threshold_ff);
      end
   end

   always_ff @(posedge clock) begin
      cell_out_ff <= cell_out_in;
      mean_out_ff <= mean_out_in;
      peak_out_ff <= peak_out_in;
   end

   assign rsp_cell_count = cell_out_ff;
   assign rsp_local_mean = mean_out_ff;
   assign rsp_is_peak = peak_out_ff;

endmodule

@@ src/hough_line_accumulator.sv @@
// Top level of the Hough line accumulator: controller and datapath.
// A vote transaction with pixel 255 occupies the block for 181 angle updates through the
// store's read-modify-write pipeline plus drain; other votes are accepted and dropped.
// A read transaction reads 25 cells one per cycle and then offers its result; a clear
// transaction zeroes the addressed cell. One transaction is in work at a time.
// Synchronous reset; afterwards a clearing pass writes zero to all RHO_BINS*181 cells
// (185344 cells by default) before the first transaction is accepted.
module hough_line_accumulator
   import hla_pkg::*;
#(
   parameter int RHO_BINS = 1024
) (
   input  logic          clock,
   input  logic          reset,
   hla_req_if.sink       req_bus,
   hla_rsp_if.source     rsp_bus,
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic [10:0]   csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller steps through the angle sweep of a vote, the 5x5 neighbourhood
   // walk of a read and the post-reset clearing pass; the datapath holds the store.
   hla_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_kind        (req_bus.kind),
      .req_pixel_value (req_bus.pixel_value),
      .req_ready       (req_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .cmd             (cmd),
      .status          (status)
   );

   hla_datapath #(
      .RHO_BINS (RHO_BINS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_pixel_row   (req_bus.pixel_row),
      .req_pixel_col   (req_bus.pixel_col),
      .req_rho_index   (req_bus.rho_index),
      .req_angle_index (req_bus.angle_index),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .rsp_cell_count  (rsp_bus.cell_count),
      .rsp_local_mean  (rsp_bus.local_mean),
      .rsp_is_peak     (rsp_bus.is_peak)
   );

endmodule
